// ===== rtl/range_reduce_segment_tree_top_macros.svh =====
// Assertion macros used by the range reduce segment tree top level.
`ifndef RANGE_REDUCE_SEGMENT_TREE_TOP_MACROS_SVH
`define RANGE_REDUCE_SEGMENT_TREE_TOP_MACROS_SVH

// Checks a property in every cycle outside reset.
`define RRST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define RRST_IMPLY_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rrst_pkg.sv =====
// Package with types, constants and helpers of the range reduce segment tree.
package rrst_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VAL_W        = 32;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;
    localparam int NODE_W       = 11;
    localparam int STACK_DEPTH  = 16;
    localparam int STK_IDX_W    = 4;
    localparam int SP_W         = 5;
    localparam int SHIFT_W      = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;

    localparam logic [CFG_IDX_W-1:0] REG_OPERATION     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd1;

    typedef enum logic [1:0] {
        OP_MIN,
        OP_MAX,
        OP_SUM,
        OP_GCD
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_Q_POP,
        S_Q_RD,
        S_Q_WAIT,
        S_DONE,
        S_W_DOWN,
        S_W_UP,
        S_W_RD1,
        S_W_RD2,
        S_W_WAIT
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [NODE_W-1:0] np;
    } stk_entry_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } cmb_req_t;

    function automatic logic [VAL_W-1:0] identity_of(op_t op);
        logic [VAL_W-1:0] id;
        unique case (op)
            OP_MIN:  id = {1'b0, {(VAL_W-1){1'b1}}};
            OP_MAX:  id = {1'b1, {(VAL_W-1){1'b0}}};
            default: id = '0;
        endcase
        return id;
    endfunction

endpackage

// ===== rtl/rrst_combine.sv =====
// Shared combine unit: min, max and sum registered straight from the operands, binary gcd by an iterative loop.
module rrst_combine
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  rrst_pkg::cmb_req_t       req,
    input  logic [rrst_pkg::VAL_W-1:0] a,
    input  logic [rrst_pkg::VAL_W-1:0] b,
    output logic                     done,
    output logic [rrst_pkg::VAL_W-1:0] result
);
    import rrst_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [VAL_W-1:0]    ga_reg, ga_next;
    logic [VAL_W-1:0]    gb_reg, gb_next;
    logic [SHIFT_W-1:0]  k_reg, k_next;
    logic [VAL_W-1:0]    res_reg, res_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ga_next   = ga_reg;
        gb_next   = gb_reg;
        k_next    = k_reg;
        res_next  = res_reg;
        if (busy_reg)
        begin
            priority if (ga_reg == '0)
            begin
                res_next  = gb_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (gb_reg == '0)
            begin
                res_next  = ga_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!ga_reg[0] && !gb_reg[0])
            begin
                ga_next = ga_reg >> 1;
                gb_next = gb_reg >> 1;
                k_next  = k_reg + 1'b1;
            end
            else if (!ga_reg[0])
            begin
                ga_next = ga_reg >> 1;
            end
            else if (!gb_reg[0])
            begin
                gb_next = gb_reg >> 1;
            end
            else if (ga_reg >= gb_reg)
            begin
                ga_next = ga_reg - gb_reg;
            end
            else
            begin
                gb_next = gb_reg - ga_reg;
            end
        end
        else if (req.start)
        begin
            unique case (req.op)
                OP_MIN:
                begin
                    res_next  = ($signed(b) < $signed(a)) ? b : a;
                    done_next = 1'b1;
                end
                OP_MAX:
                begin
                    res_next  = ($signed(a) < $signed(b)) ? b : a;
                    done_next = 1'b1;
                end
                OP_SUM:
                begin
                    res_next  = a + b;
                    done_next = 1'b1;
                end
                default:
                begin
                    ga_next   = a;
                    gb_next   = b;
                    k_next    = '0;
                    busy_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ga_reg  <= ga_next;
        gb_reg  <= gb_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/range_reduce_segment_tree_top.sv =====
// Top level of the range reduce segment tree: sequencer, node memory and node stack.
//
// Channel   Direction  Handshake             Contents
// input     in         in_valid / in_stall   kind, index, value, range_start, range_end
// output    out        out_valid / out_stall reduced_value
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A write walks down to its leaf, writes it, then combines both children of each
// node on the way up; a query pops nodes off the stack and combines each covered one.
// Gcd combines run in the shared binary gcd unit. No item is taken until the last is
// done. After reset and after every register write, a clearing pass fills the node
// memory with the identity, one node a cycle, and no item is taken meanwhile.
// A stalled output holds the finished query result until its transaction completes.
module range_reduce_segment_tree_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [rrst_pkg::IDX_W-1:0]        index,
    input  logic signed [rrst_pkg::VAL_W-1:0] value,
    input  logic [rrst_pkg::IDX_W-1:0]        range_start,
    input  logic [rrst_pkg::IDX_W-1:0]        range_end,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [rrst_pkg::VAL_W-1:0] reduced_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rrst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrst_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rrst_pkg::*;

    `include "range_reduce_segment_tree_top_macros.svh"

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [NODE_W-1:0]   clr_reg, clr_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [VAL_W-1:0]    acc_reg, acc_next;
    logic [VAL_W-1:0]    opa_reg, opa_next;
    logic [IDX_W-1:0]    qs_reg, qs_next;
    logic [IDX_W-1:0]    qe_reg, qe_next;
    logic [IDX_W-1:0]    widx_reg, widx_next;
    logic [VAL_W-1:0]    wval_reg, wval_next;
    stk_entry_t          cur_reg, cur_next;
    logic                out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]    out_data_reg, out_data_next;

    stk_entry_t          stack_reg [STACK_DEPTH];
    logic                stk_we0, stk_we1;
    logic [STK_IDX_W-1:0] stk_a0, stk_a1;
    stk_entry_t          stk_d0, stk_d1;

    logic [VAL_W-1:0]    mem [2*MAX_ELEMENTS];
    logic                mem_we, mem_re;
    logic [NODE_W-1:0]   mem_wa, mem_ra;
    logic [VAL_W-1:0]    mem_wd;
    logic [VAL_W-1:0]    rd_data_reg;

    cmb_req_t            cmb_req;
    logic [VAL_W-1:0]    cmb_a;
    logic                cmb_done;
    logic [VAL_W-1:0]    cmb_result;
    logic                cmb_wait;

    logic [CNT_W-1:0]    n_eff;
    logic [IDX_W-1:0]    n_last;
    logic                cfg_hit;
    stk_entry_t          top;
    logic [STK_IDX_W-1:0] sp_top;
    logic [IDX_W-1:0]    mid;
    logic [NODE_W-1:0]   left_np, right_np;
    logic [VAL_W-1:0]    in_mag;

    always_comb
    begin
        priority if (count_reg == '0)
            n_eff = CNT_W'(1);
        else if (count_reg > CNT_W'(MAX_ELEMENTS))
            n_eff = CNT_W'(MAX_ELEMENTS);
        else
            n_eff = count_reg;
    end

    assign n_last   = IDX_W'(n_eff - 1'b1);
    assign cfg_hit  = cfg_valid
                      && (cfg_index == REG_OPERATION || cfg_index == REG_ELEMENT_COUNT);
    assign sp_top   = STK_IDX_W'(sp_reg - 1'b1);
    assign top      = stack_reg[sp_top];
    assign mid      = IDX_W'(({1'b0, cur_reg.lo} + {1'b0, cur_reg.hi}) >> 1);
    assign in_mag   = (value[VAL_W-1]) ? VAL_W'(-value) : value;
    assign cmb_a    = (state_reg == S_Q_RD) ? acc_reg : opa_reg;
    assign cmb_req  = '{start: (state_reg == S_Q_RD) || (state_reg == S_W_RD2), op: op_reg};
    assign cmb_wait = (state_reg == S_Q_WAIT) || (state_reg == S_W_WAIT)
                      || (state_reg == S_CLEAR);

    always_comb
    begin
        left_np  = NODE_W'({cur_reg.np, 1'b1});
        right_np = NODE_W'({cur_reg.np, 1'b0} + 12'd2);
        if (state_reg == S_Q_POP)
        begin
            left_np  = NODE_W'({top.np, 1'b1});
            right_np = NODE_W'({top.np, 1'b0} + 12'd2);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        sp_next        = sp_reg;
        acc_next       = acc_reg;
        opa_next       = opa_reg;
        qs_next        = qs_reg;
        qe_next        = qe_reg;
        widx_next      = widx_reg;
        wval_next      = wval_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        stk_we0        = 1'b0;
        stk_we1        = 1'b0;
        stk_a0         = sp_top;
        stk_a1         = sp_reg[STK_IDX_W-1:0];
        stk_d0         = cur_reg;
        stk_d1         = cur_reg;
        mem_we         = 1'b0;
        mem_wa         = clr_reg;
        mem_wd         = identity_of(op_reg);
        mem_re         = 1'b0;
        mem_ra         = left_np;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {NODE_W{1'b1}})
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next = '{lo: '0, hi: n_last, np: '0};
                    sp_next  = '0;
                    if (kind)
                    begin
                        acc_next = identity_of(op_reg);
                        qs_next  = range_start;
                        qe_next  = (range_end > n_last) ? n_last : range_end;
                        if (!(range_start > range_end || CNT_W'(range_start) >= n_eff))
                        begin
                            stk_we1 = 1'b1;
                            stk_a1  = '0;
                            stk_d1  = '{lo: '0, hi: n_last, np: '0};
                            sp_next = SP_W'(1);
                        end
                        state_next = S_Q_POP;
                    end
                    else if (CNT_W'(index) < n_eff)
                    begin
                        widx_next  = index;
                        wval_next  = (op_reg == OP_GCD) ? in_mag : value;
                        state_next = S_W_DOWN;
                    end
                end
            end
            S_Q_POP:
            begin
                if (sp_reg == '0)
                    state_next = S_DONE;
                else if (top.lo > qe_reg || top.hi < qs_reg)
                    sp_next = sp_reg - 1'b1;
                else if (qs_reg <= top.lo && qe_reg >= top.hi)
                begin
                    sp_next    = sp_reg - 1'b1;
                    mem_re     = 1'b1;
                    mem_ra     = top.np;
                    state_next = S_Q_RD;
                end
                else
                begin
                    stk_we0 = 1'b1;
                    stk_d0  = '{lo: IDX_W'(({1'b0, top.lo} + {1'b0, top.hi}) >> 1) + 1'b1,
                                hi: top.hi, np: right_np};
                    stk_we1 = 1'b1;
                    stk_d1  = '{lo: top.lo,
                                hi: IDX_W'(({1'b0, top.lo} + {1'b0, top.hi}) >> 1),
                                np: left_np};
                    sp_next = sp_reg + 1'b1;
                end
            end
            S_Q_RD:
            begin
                state_next = S_Q_WAIT;
            end
            S_Q_WAIT:
            begin
                if (cmb_done)
                begin
                    acc_next   = cmb_result;
                    state_next = S_Q_POP;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            S_W_DOWN:
            begin
                if (cur_reg.lo == cur_reg.hi)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = cur_reg.np;
                    mem_wd     = wval_reg;
                    state_next = S_W_UP;
                end
                else
                begin
                    stk_we1 = 1'b1;
                    sp_next = sp_reg + 1'b1;
                    if (widx_reg > mid)
                        cur_next = '{lo: mid + 1'b1, hi: cur_reg.hi, np: right_np};
                    else
                        cur_next = '{lo: cur_reg.lo, hi: mid, np: left_np};
                end
            end
            S_W_UP:
            begin
                if (sp_reg == '0)
                    state_next = S_IDLE;
                else
                begin
                    cur_next   = top;
                    sp_next    = sp_reg - 1'b1;
                    mem_re     = 1'b1;
                    mem_ra     = NODE_W'({top.np, 1'b1});
                    state_next = S_W_RD1;
                end
            end
            S_W_RD1:
            begin
                opa_next   = rd_data_reg;
                mem_re     = 1'b1;
                mem_ra     = right_np;
                state_next = S_W_RD2;
            end
            S_W_RD2:
            begin
                state_next = S_W_WAIT;
            end
            S_W_WAIT:
            begin
                if (cmb_done)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = cur_reg.np;
                    mem_wd     = cmb_result;
                    state_next = S_W_UP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_hit)
        begin
            if (cfg_index == REG_OPERATION)
                op_next = op_t'(cfg_data[1:0]);
            else
                count_next = cfg_data;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_reg        <= OP_MIN;
            count_reg     <= CNT_W'(MAX_ELEMENTS);
            clr_reg       <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        opa_reg      <= opa_next;
        qs_reg       <= qs_next;
        qe_reg       <= qe_next;
        widx_reg     <= widx_next;
        wval_reg     <= wval_next;
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
        if (stk_we0)
            stack_reg[stk_a0] <= stk_d0;
        if (stk_we1)
            stack_reg[stk_a1] <= stk_d1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

    rrst_combine u_combine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (cmb_req),
        .a      (cmb_a),
        .b      (rd_data_reg),
        .done   (cmb_done),
        .result (cmb_result)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign reduced_value = out_data_reg;

    `RRST_ASSERT(a_stack_bound, sp_reg <= SP_W'(STACK_DEPTH), "node stack overflow")
    `RRST_ASSERT(a_done_when_waiting, !cmb_done || cmb_wait, "combine result outside a wait")
    `RRST_IMPLY_NEXT(a_cfg_clears, cfg_hit, state_reg == S_CLEAR && clr_reg == '0, "no clear")
    `RRST_IMPLY_NEXT(a_cmb_start, cmb_req.start, cmb_wait, "combine started without waiting")

endmodule
